// File: sv/bfd_pkg.sv
// Shared types and constants of the box-filter frame downscaler.
package bfd_pkg;

  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 8;
  localparam int CELL_IDX_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] RESET_SRC_WIDTH  = CFG_W'(32);
  localparam logic [CFG_W-1:0] RESET_SRC_HEIGHT = CFG_W'(18);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic setup_start;
    logic load_edges;
    logic pix_en;
    logic div_start;
    logic out_load;
  } bfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic restart;
    logic setup_done;
    logic cell_end;
    logic div_done;
  } bfd_sts_t;

endpackage

// File: sv/bfd_div.sv
// Restoring divider that produces one quotient bit per cycle.
module bfd_div #(
  parameter int DW = 23,
  parameter int NW = 15,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int SW  = NW + QW;
  localparam int W   = (DW > SW) ? DW : SW;
  localparam int CTW = $clog2(QW + 1);

  logic [SW-1:0]  dsh;
  logic [CTW-1:0] cnt;
  logic [W-1:0]   rem_w;
  logic [W-1:0]   dsh_w;
  logic [W-1:0]   diff;
  logic           ge;

  // The caller guarantees dividend < divisor * 2**QW, so QW steps suffice.
  assign rem_w = W'(rem);
  assign dsh_w = W'(dsh);
  assign ge    = rem_w >= dsh_w;
  assign diff  = rem_w - dsh_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CTW'(QW);
    end else if (busy) begin
      if (cnt == CTW'(1)) begin
        busy <= 1'b0;
      end
      cnt <= cnt - CTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsh  <= SW'(divisor) << (QW - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= DW'(diff);
      end
      quot <= (quot << 1) | QW'(ge);
      dsh  <= dsh >> 1;
    end
  end

endmodule

// File: sv/bfd_ctrl.sv
// Controller state machine of the downscaler: setup, pixel intake and division sequencing.
module bfd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bfd_pkg::bfd_sts_t  sts,
  output bfd_pkg::bfd_cmd_t  cmd
);

  import bfd_pkg::*;

  typedef enum logic [1:0] {
    S_START,
    S_SETUP,
    S_RUN,
    S_DIV
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready        = (state == S_RUN);
    cmd.setup_start = (state == S_START);
    cmd.load_edges  = (state == S_SETUP) && sts.setup_done;
    cmd.pix_en      = in_ready && in_valid;
    cmd.div_start   = cmd.pix_en && sts.cell_end;
    cmd.out_load    = (state == S_DIV) && sts.div_done && (!out_valid || out_ready);

    state_next = state;
    unique case (state)
      S_START: state_next = S_SETUP;
      S_SETUP: begin
        if (sts.setup_done) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd.div_start) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (cmd.out_load) begin
          state_next = S_RUN;
        end
      end
      default: state_next = S_START;
    endcase
    // A register write restarts the frame from any state.
    if (sts.restart) begin
      state_next = S_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_START;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/bfd_dp.sv
// Datapath of the downscaler: geometry counters, column accumulators, dividers and result register.
module bfd_dp #(
  parameter int OUT_COLS    = 32,
  parameter int OUT_ROWS    = 18,
  parameter int MAX_SRC_DIM = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]        cfg_data,
  input  logic [bfd_pkg::PIX_W-1:0]        red,
  input  logic [bfd_pkg::PIX_W-1:0]        green,
  input  logic [bfd_pkg::PIX_W-1:0]        blue,
  input  bfd_pkg::bfd_cmd_t                cmd,
  output bfd_pkg::bfd_sts_t                sts,
  output logic [bfd_pkg::PIX_W-1:0]        avg_red,
  output logic [bfd_pkg::PIX_W-1:0]        avg_green,
  output logic [bfd_pkg::PIX_W-1:0]        avg_blue,
  output logic [bfd_pkg::CELL_IDX_W-1:0]   cell_col,
  output logic [bfd_pkg::CELL_IDX_W-1:0]   cell_row,
  output logic                             frame_last
);

  import bfd_pkg::*;

  localparam int COL_W   = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1;
  localparam int ROW_W   = (OUT_ROWS > 1) ? $clog2(OUT_ROWS) : 1;
  localparam int NCW     = $clog2(OUT_COLS + 1);
  localparam int NRW     = $clog2(OUT_ROWS + 1);
  localparam int DIM_CAP = (MAX_SRC_DIM > (2 ** CFG_W) - 1) ? (2 ** CFG_W) - 1 : MAX_SRC_DIM;
  localparam int CELL_WX = DIM_CAP / OUT_COLS + 1;
  localparam int CELL_HY = DIM_CAP / OUT_ROWS + 1;
  localparam int CNT_W   = $clog2(CELL_WX * CELL_HY + 1);
  localparam int SUM_W   = CNT_W + PIX_W;

  localparam logic [CFG_W-1:0] DIM_MAX = CFG_W'(DIM_CAP);

  // Configuration registers and effective sizes.
  logic [CFG_W-1:0] src_width;
  logic [CFG_W-1:0] src_height;
  logic [CFG_W-1:0] eff_w;
  logic [CFG_W-1:0] eff_h;
  logic [NCW-1:0]   n_cols;
  logic [NRW-1:0]   n_rows;

  // Status terms gathered into the status bundle.
  logic             cfg_hit;
  logic             setup_done;
  logic             cell_end;
  logic             div_done;

  // Geometry state.
  logic [CFG_W-1:0] src_x;
  logic [CFG_W-1:0] src_y;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [CFG_W-1:0] col_edge;
  logic [CFG_W-1:0] row_edge;
  logic [NCW-1:0]   col_rem;
  logic [NRW-1:0]   row_rem;

  // Edge step: dimension = q * n + r.
  logic [CFG_W-1:0] q_w;
  logic [CFG_W-1:0] r_w;
  logic [CFG_W-1:0] q_h;
  logic [CFG_W-1:0] r_h;
  logic             busy_w;
  logic             busy_h;

  logic [CFG_W:0]   x_inc;
  logic [CFG_W:0]   y_inc;
  logic             col_hit;
  logic             row_hit;
  logic             x_wrap;
  logic             y_wrap;
  logic             last_cell;

  logic [NCW:0]     col_rsum;
  logic             col_carry;
  logic [NCW-1:0]   col_rem_next;
  logic [CFG_W-1:0] col_edge_next;
  logic [NRW:0]     row_rsum;
  logic             row_carry;
  logic [NRW-1:0]   row_rem_next;
  logic [CFG_W-1:0] row_edge_next;

  // Column accumulators; an entry without its valid bit reads as zero.
  logic [SUM_W-1:0] acc_r [OUT_COLS];
  logic [SUM_W-1:0] acc_g [OUT_COLS];
  logic [SUM_W-1:0] acc_b [OUT_COLS];
  logic [CNT_W-1:0] acc_n [OUT_COLS];
  logic [OUT_COLS-1:0] acc_vld;

  logic [SUM_W-1:0] sum_r_new;
  logic [SUM_W-1:0] sum_g_new;
  logic [SUM_W-1:0] sum_b_new;
  logic [CNT_W-1:0] cnt_new;

  logic [PIX_W-1:0] q_r;
  logic [PIX_W-1:0] q_g;
  logic [PIX_W-1:0] q_b;
  logic             busy_r;
  logic             busy_g;
  logic             busy_b;

  logic [COL_W-1:0] pend_col;
  logic [ROW_W-1:0] pend_row;
  logic             pend_last;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  cfg_hit = 1'b1;
        REG_SRC_HEIGHT: cfg_hit = 1'b1;
        default:        cfg_hit = 1'b0;
      endcase
    end
  end

  assign sts = {cfg_hit, setup_done, cell_end, div_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= RESET_SRC_WIDTH;
      src_height <= RESET_SRC_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // A size of zero acts as one; sizes above the limit are clipped.
  assign eff_w = (src_width == '0) ? CFG_W'(1) :
                 ((src_width > DIM_MAX) ? DIM_MAX : src_width);
  assign eff_h = (src_height == '0) ? CFG_W'(1) :
                 ((src_height > DIM_MAX) ? DIM_MAX : src_height);
  assign n_cols = (32'(eff_w) < OUT_COLS) ? NCW'(eff_w) : NCW'(OUT_COLS);
  assign n_rows = (32'(eff_h) < OUT_ROWS) ? NRW'(eff_h) : NRW'(OUT_ROWS);

  bfd_div #(.DW(CFG_W), .NW(NCW), .QW(CFG_W)) u_div_w (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.setup_start),
    .dividend (eff_w),
    .divisor  (n_cols),
    .busy     (busy_w),
    .quot     (q_w),
    .rem      (r_w)
  );

  bfd_div #(.DW(CFG_W), .NW(NRW), .QW(CFG_W)) u_div_h (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.setup_start),
    .dividend (eff_h),
    .divisor  (n_rows),
    .busy     (busy_h),
    .quot     (q_h),
    .rem      (r_h)
  );

  assign setup_done = !busy_w && !busy_h;

  assign x_inc   = {1'b0, src_x} + (CFG_W + 1)'(1);
  assign y_inc   = {1'b0, src_y} + (CFG_W + 1)'(1);
  assign col_hit = x_inc >= {1'b0, col_edge};
  assign row_hit = y_inc >= {1'b0, row_edge};
  assign x_wrap  = x_inc >= {1'b0, eff_w};
  assign y_wrap  = (y_inc >= {1'b0, eff_h}) ||
                   ((32'(cur_row) + 32'd1) >= 32'(n_rows));
  assign cell_end = col_hit && row_hit;
  assign last_cell = ((32'(cur_col) + 32'd1) >= 32'(n_cols)) &&
                     ((32'(cur_row) + 32'd1) >= 32'(n_rows));

  // Next edge = edge + q, plus one whenever the running remainder reaches n.
  assign col_rsum      = {1'b0, col_rem} + (NCW + 1)'(r_w);
  assign col_carry     = col_rsum >= {1'b0, n_cols};
  assign col_rem_next  = col_carry ? NCW'(col_rsum - {1'b0, n_cols}) : NCW'(col_rsum);
  assign col_edge_next = col_edge + q_w + CFG_W'(col_carry);
  assign row_rsum      = {1'b0, row_rem} + (NRW + 1)'(r_h);
  assign row_carry     = row_rsum >= {1'b0, n_rows};
  assign row_rem_next  = row_carry ? NRW'(row_rsum - {1'b0, n_rows}) : NRW'(row_rsum);
  assign row_edge_next = row_edge + q_h + CFG_W'(row_carry);

  always_ff @(posedge clk) begin
    if (rst || cmd.setup_start) begin
      src_x   <= '0;
      src_y   <= '0;
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.pix_en) begin
      if (x_wrap) begin
        src_x   <= '0;
        cur_col <= '0;
        if (row_hit && y_wrap) begin
          src_y   <= '0;
          cur_row <= '0;
        end else begin
          src_y <= CFG_W'(y_inc);
          if (row_hit) begin
            cur_row <= cur_row + ROW_W'(1);
          end
        end
      end else begin
        src_x <= CFG_W'(x_inc);
        if (col_hit) begin
          cur_col <= cur_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edges) begin
      col_edge <= q_w;
      col_rem  <= NCW'(r_w);
      row_edge <= q_h;
      row_rem  <= NRW'(r_h);
    end else if (cmd.pix_en) begin
      if (x_wrap) begin
        col_edge <= q_w;
        col_rem  <= NCW'(r_w);
        if (row_hit) begin
          if (y_wrap) begin
            row_edge <= q_h;
            row_rem  <= NRW'(r_h);
          end else begin
            row_edge <= row_edge_next;
            row_rem  <= row_rem_next;
          end
        end
      end else if (col_hit) begin
        col_edge <= col_edge_next;
        col_rem  <= col_rem_next;
      end
    end
  end

  assign sum_r_new = (acc_vld[cur_col] ? acc_r[cur_col] : '0) + SUM_W'(red);
  assign sum_g_new = (acc_vld[cur_col] ? acc_g[cur_col] : '0) + SUM_W'(green);
  assign sum_b_new = (acc_vld[cur_col] ? acc_b[cur_col] : '0) + SUM_W'(blue);
  assign cnt_new   = (acc_vld[cur_col] ? acc_n[cur_col] : '0) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst || cmd.setup_start) begin
      acc_vld <= '0;
    end else if (cmd.pix_en) begin
      // The entry of a finished cell starts over empty.
      acc_vld[cur_col] <= !cell_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_en) begin
      acc_r[cur_col] <= sum_r_new;
      acc_g[cur_col] <= sum_g_new;
      acc_b[cur_col] <= sum_b_new;
      acc_n[cur_col] <= cnt_new;
    end
  end

  bfd_div #(.DW(SUM_W), .NW(CNT_W), .QW(PIX_W)) u_div_r (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_r_new),
    .divisor  (cnt_new),
    .busy     (busy_r),
    .quot     (q_r),
    .rem      ()
  );

  bfd_div #(.DW(SUM_W), .NW(CNT_W), .QW(PIX_W)) u_div_g (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_g_new),
    .divisor  (cnt_new),
    .busy     (busy_g),
    .quot     (q_g),
    .rem      ()
  );

  bfd_div #(.DW(SUM_W), .NW(CNT_W), .QW(PIX_W)) u_div_b (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_b_new),
    .divisor  (cnt_new),
    .busy     (busy_b),
    .quot     (q_b),
    .rem      ()
  );

  assign div_done = !(busy_r || busy_g || busy_b);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      pend_col  <= cur_col;
      pend_row  <= cur_row;
      pend_last <= last_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      avg_red    <= q_r;
      avg_green  <= q_g;
      avg_blue   <= q_b;
      cell_col   <= CELL_IDX_W'(pend_col);
      cell_row   <= CELL_IDX_W'(pend_row);
      frame_last <= pend_last;
    end
  end

endmodule

// File: sv/box_filter_image_downscale_top.sv
// Top level of the box-filter frame downscaler.
//
// Source pixels enter on in_valid/in_ready in raster order, one red, green and
// blue byte per transfer. Each finished cell of the overview grid leaves as one
// transfer on out_valid/out_ready: the truncated channel means, the cell's
// column and row, and frame_last on the final cell of the frame.
// Frame sizes are written on the cfg_valid/cfg_ready port (index 0 width,
// index 1 height); every write to either register restarts the frame.
// After reset or such a write the edge step of the cell grid is worked out by
// a 13-step divider, and in_ready stays low until that divider has finished.
// Pixels that close no cell stream at one per clock. A pixel that closes a cell
// starts the three 8-step mean dividers; the result is registered once they
// have all finished, and in_ready returns when the result is registered.
// The output register lets pixels flow on while a result waits; if the
// receiver still holds the previous result when the next mean is ready, the
// block keeps in_ready low until that result has been taken.
// Reset restores the sizes 32 by 18 and empties all column accumulators.
module box_filter_image_downscale_top #(
  parameter int OUT_COLS    = 32,
  parameter int OUT_ROWS    = 18,
  parameter int MAX_SRC_DIM = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bfd_pkg::PIX_W-1:0]        red,
  input  logic [bfd_pkg::PIX_W-1:0]        green,
  input  logic [bfd_pkg::PIX_W-1:0]        blue,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bfd_pkg::PIX_W-1:0]        avg_red,
  output logic [bfd_pkg::PIX_W-1:0]        avg_green,
  output logic [bfd_pkg::PIX_W-1:0]        avg_blue,
  output logic [bfd_pkg::CELL_IDX_W-1:0]   cell_col,
  output logic [bfd_pkg::CELL_IDX_W-1:0]   cell_row,
  output logic                             frame_last
);

  import bfd_pkg::*;

  bfd_cmd_t cmd;
  bfd_sts_t sts;

  assign cfg_ready = 1'b1;

  bfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfd_dp #(
    .OUT_COLS    (OUT_COLS),
    .OUT_ROWS    (OUT_ROWS),
    .MAX_SRC_DIM (MAX_SRC_DIM)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .cmd        (cmd),
    .sts        (sts),
    .avg_red    (avg_red),
    .avg_green  (avg_green),
    .avg_blue   (avg_blue),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .frame_last (frame_last)
  );

  // Input is held off while a cell mean is being divided.
  a_div_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !in_ready)
    else $error("pixel intake open during division");

  // A result is only registered once all dividers have finished.
  a_load_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.div_done)
    else $error("result loaded before division finished");

  // A register write always leads into the setup sequence.
  a_restart_setup: assert property (@(posedge clk) disable iff (rst)
    sts.restart |=> cmd.setup_start)
    else $error("register write did not restart the frame");

  // A new result appears only through a load from the dividers.
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid raised without a load");

endmodule

// File: tb/sv/bfd_checker.sv
// Checker for the box-filter frame downscaler: predicts cell means and compares results.
`timescale 1ns / 100ps

module bfd_checker #(
  parameter int OUT_COLS    = 32,
  parameter int OUT_ROWS    = 18,
  parameter int MAX_SRC_DIM = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [bfd_pkg::PIX_W-1:0]        red,
  input  logic [bfd_pkg::PIX_W-1:0]        green,
  input  logic [bfd_pkg::PIX_W-1:0]        blue,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [bfd_pkg::PIX_W-1:0]        avg_red,
  input  logic [bfd_pkg::PIX_W-1:0]        avg_green,
  input  logic [bfd_pkg::PIX_W-1:0]        avg_blue,
  input  logic [bfd_pkg::CELL_IDX_W-1:0]   cell_col,
  input  logic [bfd_pkg::CELL_IDX_W-1:0]   cell_row,
  input  logic                             frame_last,
  output int                               mismatches,
  output int                               outstanding
);
  import bfd_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0]      r;
    logic [PIX_W-1:0]      g;
    logic [PIX_W-1:0]      b;
    logic [CELL_IDX_W-1:0] col;
    logic [CELL_IDX_W-1:0] row;
    logic                  last;
  } cell_mean_t;

  cell_mean_t cell_means[$];

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  int unsigned sum_red[OUT_COLS];
  int unsigned sum_green[OUT_COLS];
  int unsigned sum_blue[OUT_COLS];
  int unsigned pix_count[OUT_COLS];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned band_col;
  int unsigned band_row;
  int unsigned col_end;
  int unsigned row_end;

  int fail_count = 0;

  assign mismatches = fail_count;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SRC_DIM) return MAX_SRC_DIM;
    return v;
  endfunction

  function automatic int unsigned grid_cols();
    int unsigned w;
    w = clamp_dim(width_reg);
    return (w < OUT_COLS) ? w : OUT_COLS;
  endfunction

  function automatic int unsigned grid_rows();
    int unsigned h;
    h = clamp_dim(height_reg);
    return (h < OUT_ROWS) ? h : OUT_ROWS;
  endfunction

  // Exclusive end of cell idx when a dimension of size dim is split n ways.
  function automatic int unsigned split_end(input int unsigned idx, input int unsigned dim,
                                            input int unsigned n);
    return ((idx + 1) * dim) / n;
  endfunction

  task automatic start_frame();
    for (int i = 0; i < OUT_COLS; i++) begin
      sum_red[i]   = 0;
      sum_green[i] = 0;
      sum_blue[i]  = 0;
      pix_count[i] = 0;
    end
    col_pos  = 0;
    row_pos  = 0;
    band_col = 0;
    band_row = 0;
    col_end  = split_end(0, clamp_dim(width_reg), grid_cols());
    row_end  = split_end(0, clamp_dim(height_reg), grid_rows());
  endtask

  task automatic accumulate_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                  input logic [PIX_W-1:0] b);
    int unsigned w;
    int unsigned h;
    int unsigned oc;
    int unsigned orr;
    int unsigned c;
    int unsigned n;
    cell_mean_t  m;
    w   = clamp_dim(width_reg);
    h   = clamp_dim(height_reg);
    oc  = grid_cols();
    orr = grid_rows();
    c   = (band_col < OUT_COLS) ? band_col : OUT_COLS - 1;

    sum_red[c]   += r;
    sum_green[c] += g;
    sum_blue[c]  += b;
    pix_count[c] += 1;

    if (col_pos + 1 >= col_end) begin
      // The pixel ends this column's span in the row; on the band's last row it ends the cell.
      if (row_pos + 1 >= row_end) begin
        n      = pix_count[c];
        m.r    = PIX_W'(sum_red[c] / n);
        m.g    = PIX_W'(sum_green[c] / n);
        m.b    = PIX_W'(sum_blue[c] / n);
        m.col  = CELL_IDX_W'(band_col);
        m.row  = CELL_IDX_W'(band_row);
        m.last = (band_col + 1 >= oc) && (band_row + 1 >= orr);
        cell_means = {cell_means, m};
        sum_red[c]   = 0;
        sum_green[c] = 0;
        sum_blue[c]  = 0;
        pix_count[c] = 0;
      end
      band_col += 1;
      if (band_col < oc) col_end = split_end(band_col, w, oc);
    end

    col_pos += 1;
    if (col_pos >= w) begin
      col_pos  = 0;
      band_col = 0;
      col_end  = split_end(0, w, oc);
      row_pos += 1;
      if (row_pos >= row_end) begin
        band_row += 1;
        if (row_pos >= h || band_row >= orr) begin
          row_pos  = 0;
          band_row = 0;
        end
        row_end = split_end(band_row, h, orr);
      end
    end
  endtask

  always @(posedge clk) begin
    cell_mean_t want;
    if (rst) begin
      width_reg  = RESET_SRC_WIDTH;
      height_reg = RESET_SRC_HEIGHT;
      start_frame();
      cell_means.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (cell_means.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected cell: r%0d g%0d b%0d col%0d row%0d last%0d",
                     avg_red, avg_green, avg_blue, cell_col, cell_row, frame_last);
        end else begin
          want = cell_means.pop_front();
          if (want.r !== avg_red || want.g !== avg_green || want.b !== avg_blue ||
              want.col !== cell_col || want.row !== cell_row || want.last !== frame_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("cell mismatch: want r%0d g%0d b%0d col%0d row%0d last%0d, %s",
                       want.r, want.g, want.b, want.col, want.row, want.last,
                       $sformatf("got r%0d g%0d b%0d col%0d row%0d last%0d",
                                 avg_red, avg_green, avg_blue, cell_col, cell_row,
                                 frame_last));
          end
        end
      end

      // Any write to a size register throws away the frame in progress.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_WIDTH: begin
            width_reg = cfg_data;
            start_frame();
          end
          REG_SRC_HEIGHT: begin
            height_reg = cfg_data;
            start_frame();
          end
          default: begin
          end
        endcase
      end

      if (in_valid && in_ready) accumulate_pixel(red, green, blue);

      outstanding <= cell_means.size();
    end
  end

endmodule

// File: tb/sv/tb_box_filter_image_downscale_top.sv
// Testbench top for the box-filter frame downscaler: stimulus, pacing and verdict.
`timescale 1ns / 100ps

module tb_box_filter_image_downscale_top;
  import bfd_pkg::*;

  localparam int OUT_COLS         = 32;
  localparam int OUT_ROWS         = 18;
  localparam int MAX_DIM          = 4096;
  localparam int PIXEL_TARGET     = 1250;
  localparam int SETTLE_CYCLES    = 24;
  localparam int LONG_HOLD_AT     = 50;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int MAX_PHASE_PIXELS = 400;

  // Indexes with no register behind them; the block must ignore writes there.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      red;
  logic [PIX_W-1:0]      green;
  logic [PIX_W-1:0]      blue;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIX_W-1:0]      avg_red;
  logic [PIX_W-1:0]      avg_green;
  logic [PIX_W-1:0]      avg_blue;
  logic [CELL_IDX_W-1:0] cell_col;
  logic [CELL_IDX_W-1:0] cell_row;
  logic                  frame_last;
  int                    mismatches;
  int                    outstanding;

  logic [CFG_W-1:0] cur_width;
  logic [CFG_W-1:0] cur_height;
  int               pixels_sent;
  int               send_streak;

  box_filter_image_downscale_top #(
    .OUT_COLS   (OUT_COLS),
    .OUT_ROWS   (OUT_ROWS),
    .MAX_SRC_DIM(MAX_DIM)
  ) dut (.*);

  bfd_checker #(
    .OUT_COLS   (OUT_COLS),
    .OUT_ROWS   (OUT_ROWS),
    .MAX_SRC_DIM(MAX_DIM)
  ) checker_i (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Waits until every predicted cell has been taken and the block has had time to settle.
  task automatic wait_idle();
    do begin
      while (outstanding != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SRC_WIDTH) cur_width = value;
    if (idx == REG_SRC_HEIGHT) cur_height = value;
    @(posedge clk);
  endtask

  // Offers one pixel and returns at the edge of its transfer, leaving in_valid high.
  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b);
    int gap;
    if (send_streak > 0) begin
      send_streak--;
      gap = 0;
    end else if ($urandom_range(0, 39) == 0) begin
      send_streak = $urandom_range(20, 60);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  task automatic run_pixels(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                 PIX_W'($urandom_range(0, 255)));
    in_valid <= 1'b0;
  endtask

  // Result side: random stalls per transfer, runs without stalls, and one long hold-off.
  initial begin
    int gap;
    int taken;
    int streak;
    taken  = 0;
    streak = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (streak > 0) begin
        streak--;
        gap = 0;
      end else if ($urandom_range(0, 39) == 0) begin
        streak = $urandom_range(20, 60);
        gap = 0;
      end else begin
        gap = $urandom_range(0, 11);
      end
      if (taken == LONG_HOLD_AT) gap = LONG_HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    int               kind;
    int               count;
    int               eff_w;
    int               eff_h;
    logic [CFG_W-1:0] new_w;
    logic [CFG_W-1:0] new_h;
    pixels_sent = 0;
    send_streak = 0;
    cur_width   = RESET_SRC_WIDTH;
    cur_height  = RESET_SRC_HEIGHT;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SRC_WIDTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    red       <= '0;
    green     <= '0;
    blue      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes give one-pixel cells, so each pixel comes straight back.
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'h0F);
    send_pixel(8'h01, 8'h80, 8'hFE);
    in_valid <= 1'b0;

    // A one-pixel frame: every pixel is the final cell.
    write_reg(REG_SRC_WIDTH, 13'd1);
    write_reg(REG_SRC_HEIGHT, 13'd1);
    run_pixels(3);

    // Zero sizes behave as one.
    write_reg(REG_SRC_WIDTH, 13'd0);
    run_pixels(2);
    write_reg(REG_SRC_HEIGHT, 13'd0);
    run_pixels(1);

    // Two-pixel cells, where the means truncate.
    write_reg(REG_SRC_WIDTH, 13'd64);
    write_reg(REG_SRC_HEIGHT, 13'd1);
    send_pixel(8'hFF, 8'h00, 8'h01);
    send_pixel(8'hFE, 8'h01, 8'h02);
    send_pixel(8'h03, 8'h03, 8'h03);
    send_pixel(8'h04, 8'h04, 8'h06);
    in_valid <= 1'b0;

    // Oversized frame; writes to the spare indexes must not restart it.
    write_reg(REG_SRC_WIDTH, 13'h1FFF);
    write_reg(REG_SRC_HEIGHT, 13'h1FFF);
    run_pixels(3);
    write_reg(REG_SPARE_LO, 13'h1555);
    run_pixels(2);
    write_reg(REG_SPARE_HI, 13'h0AAA);
    run_pixels(1);

    while (pixels_sent < PIXEL_TARGET) begin
      kind = $urandom_range(0, 19);
      case (kind)
        0: begin
          // Full-width rows: the first cell closes after 128 pixels.
          new_w = ($urandom_range(0, 1) == 1) ? 13'd4096 : 13'h1FFF;
          new_h = CFG_W'($urandom_range(0, 3));
          write_reg(REG_SRC_WIDTH, new_w);
          write_reg(REG_SRC_HEIGHT, new_h);
          count = 150;
        end
        1: begin
          new_w = ($urandom_range(0, 3) == 0) ? 13'd4096 : CFG_W'($urandom_range(1, 40));
          new_h = ($urandom_range(0, 1) == 1) ? 13'd4096 : CFG_W'($urandom_range(1000, 8191));
          write_reg(REG_SRC_HEIGHT, new_h);
          write_reg(REG_SRC_WIDTH, new_w);
          count = 120;
        end
        2: begin
          write_reg(REG_SRC_WIDTH, CFG_W'($urandom));
          write_reg(REG_SRC_HEIGHT, CFG_W'($urandom));
          count = 100;
        end
        default: begin
          new_w = CFG_W'($urandom_range(0, 48));
          new_h = CFG_W'($urandom_range(0, 24));
          if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 1) write_reg(REG_SRC_WIDTH, new_w);
            else write_reg(REG_SRC_HEIGHT, new_h);
          end else if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_SRC_WIDTH, new_w);
            write_reg(REG_SRC_HEIGHT, new_h);
          end else begin
            write_reg(REG_SRC_HEIGHT, new_h);
            write_reg(REG_SRC_WIDTH, new_w);
          end
          eff_w = (cur_width == 0) ? 1 : ((cur_width > MAX_DIM) ? MAX_DIM : int'(cur_width));
          eff_h = (cur_height == 0) ? 1 : ((cur_height > MAX_DIM) ? MAX_DIM : int'(cur_height));
          count = eff_w * eff_h * $urandom_range(1, 3);
          if (count > MAX_PHASE_PIXELS) count = MAX_PHASE_PIXELS;
          // Now and then the frame is cut short by the next size write.
          if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
        end
      endcase
      if ($urandom_range(0, 9) == 0)
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
      // The last phase stops at the pixel target.
      if (count > PIXEL_TARGET - pixels_sent) count = PIXEL_TARGET - pixels_sent;
      run_pixels(count);
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
